>>> rtl/time_window_moving_average_defines.svh
// assertion macros for the time window moving average checker
// expects signals named clock and reset in the scope of each use
`ifndef TIME_WINDOW_MOVING_AVERAGE_DEFINES_SVH
`define TIME_WINDOW_MOVING_AVERAGE_DEFINES_SVH

// antecedent in this cycle, consequent at the next clock edge
`define TWMA_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// antecedent and consequent at the same clock edge
`define TWMA_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> rtl/twma_pkg.sv
// shared types and fixed widths for the time window moving average block
// no dependencies
`default_nettype none

package twma_pkg;

   localparam int TIME_W       = 30;   // sample timestamp, ms
   localparam int PWR_IN_W     = 16;   // raw signed power
   localparam int PWR_W        = 15;   // power after clamping at zero
   localparam int HR_W         = 8;
   localparam int SEC_W        = 20;
   localparam int WIN_W        = 12;
   localparam int FRAC_W       = 8;    // 1/256 units
   localparam int QUO_W        = PWR_W + FRAC_W;
   localparam int HR_AVG_W     = 16;
   localparam int CNT_OUT_W    = 11;
   localparam int MS_W         = 10;
   localparam int LIMIT_W      = SEC_W + MS_W;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [MS_W-1:0]  MS_PER_SEC    = 10'd1000;
   localparam logic [WIN_W-1:0] WINDOW_RESET  = 12'd30;
   // register index as seen on paddr[2]
   localparam logic             CSR_IDX_WINDOW = 1'b0;

   typedef struct packed {
      logic [TIME_W-1:0] time_ms;
      logic [PWR_W-1:0]  power;
      logic [HR_W-1:0]   hr;
   } twma_entry_type;

   typedef struct packed {
      logic capture;     // latch input item, clear result
      logic push;        // store sample or flag overflow
      logic load_limit;  // register eviction limit
      logic pop;         // drop fifo head
      logic div_start;   // load both dividers
      logic div_step;    // one quotient bit
      logic load_out;    // move result to output register
   } twma_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic late;
      logic warm;
      logic head_old;
      logic count_zero;
      logic div_done;
      logic out_free;
   } twma_stat_type;

endpackage

`default_nettype wire

>>> rtl/twma_ctrl.sv
// sequencer for the time window moving average block
// depends on twma_pkg for the command and status structs
`default_nettype none

module twma_ctrl
   import twma_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_stall,
   input  wire twma_stat_type stat,
   output      twma_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_DECODE     = 3'd1;
   localparam logic [2:0] ST_EVICT_CHK  = 3'd2;
   localparam logic [2:0] ST_EVICT_WAIT = 3'd3;
   localparam logic [2:0] ST_DIV_START  = 3'd4;
   localparam logic [2:0] ST_DIV_RUN    = 3'd5;
   localparam logic [2:0] ST_FINISH     = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (!stat.is_tick) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end else if (stat.late) begin
               state_in = ST_IDLE;
            end else if (stat.warm) begin
               state_in = ST_FINISH;
            end else begin
               cmd.load_limit = 1'b1;
               state_in       = ST_EVICT_CHK;
            end
         end
         ST_EVICT_CHK: begin
            if (stat.head_old) begin
               cmd.pop  = 1'b1;
               state_in = ST_EVICT_WAIT;
            end else if (stat.count_zero) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_DIV_START;
            end
         end
         ST_EVICT_WAIT: begin
            // head read data refreshes for the new head
            state_in = ST_EVICT_CHK;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/twma_datapath.sv
// sample fifo, running sums, eviction compare, two serial dividers, output register
// depends on twma_pkg for widths and the command and status structs
`default_nettype none

module twma_datapath
   import twma_pkg::*;
#(
   parameter int FIFO_DEPTH  = 1024,
   parameter int MAX_SECONDS = 604800
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire twma_cmd_type        cmd,
   output      twma_stat_type       stat,
   input  wire logic [WIN_W-1:0]    window_seconds,
   input  wire logic                req_func,
   input  wire logic [TIME_W-1:0]   req_sample_time_ms,
   input  wire logic [PWR_IN_W-1:0] req_power_watts,
   input  wire logic [HR_W-1:0]     req_heart_rate,
   input  wire logic [SEC_W-1:0]    req_tick_second,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic [SEC_W-1:0]    rsp_out_second,
   output      logic [QUO_W-1:0]    rsp_power_avg,
   output      logic [HR_AVG_W-1:0] rsp_hr_avg,
   output      logic [CNT_OUT_W-1:0] rsp_window_count,
   output      logic                rsp_overflow
);

   localparam int PTR_W     = $clog2(FIFO_DEPTH);
   localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
   localparam int PSUM_W    = PWR_W + CNT_W;
   localparam int HSUM_W    = HR_W + CNT_W;
   localparam int DIV_CNT_W = $clog2(QUO_W);

   // captured item
   logic              func_ff;
   logic [TIME_W-1:0] time_ff;
   logic [PWR_W-1:0]  pwr_ff;
   logic [HR_W-1:0]   hr_ff;
   logic [SEC_W-1:0]  sec_ff;

   // fifo control and sums
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PSUM_W-1:0] psum_ff, psum_in;
   logic [HSUM_W-1:0] hsum_ff, hsum_in;
   logic              ovf_ff, ovf_in;
   logic              full;

   twma_entry_type    fifo_mem [FIFO_DEPTH];
   twma_entry_type    rd_ff;
   twma_entry_type    wr_entry;

   logic [LIMIT_W-1:0] limit_ff;
   logic [SEC_W-1:0]   sec_diff;

   // dividers
   logic [CNT_W-1:0]     rem_p_ff, rem_p_in;
   logic [CNT_W-1:0]     rem_h_ff, rem_h_in;
   logic [QUO_W-1:0]     qp_ff, qp_in;
   logic [QUO_W-1:0]     qh_ff, qh_in;
   logic [CNT_W-1:0]     res_cnt_ff, res_cnt_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [PSUM_W-1:0]    hsum_x;
   logic [CNT_W:0]       rp2, rh2, rp_sub, rh_sub;
   logic                 gep, geh;

   // output register
   logic                      out_valid_ff, out_valid_in;
   logic [SEC_W-1:0]          out_sec_ff;
   logic [QUO_W-1:0]          out_pavg_ff;
   logic [HR_AVG_W-1:0]       out_havg_ff;
   logic [CNT_OUT_W-1:0]      out_cnt_ff;
   logic                      out_ovf_ff;
   logic [CNT_W+CNT_OUT_W-1:0] cnt_wide;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(FIFO_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   // input capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         time_ff <= req_sample_time_ms;
         pwr_ff  <= req_power_watts[PWR_IN_W-1] ? '0 : req_power_watts[PWR_W-1:0];
         hr_ff   <= req_heart_rate;
         sec_ff  <= req_tick_second;
      end
   end

   assign full     = (count_ff == CNT_W'(FIFO_DEPTH));
   assign sec_diff = sec_ff - SEC_W'(window_seconds);

   assign stat.is_tick    = func_ff;
   assign stat.late       = (32'(sec_ff) > 32'(MAX_SECONDS));
   assign stat.warm       = (sec_ff < SEC_W'(window_seconds));
   assign stat.head_old   = (count_ff != '0) && (rd_ff.time_ms < limit_ff);
   assign stat.count_zero = (count_ff == '0);
   assign stat.div_done   = (div_cnt_ff == DIV_CNT_W'(QUO_W - 1));
   assign stat.out_free   = !out_valid_ff || !rsp_stall;

   // fifo pointers, fill count, sums, overflow
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      psum_in  = psum_ff;
      hsum_in  = hsum_ff;
      ovf_in   = ovf_ff;
      if (cmd.push) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            tail_in  = ptr_next(tail_ff);
            count_in = count_ff + 1'b1;
            psum_in  = psum_ff + PSUM_W'(pwr_ff);
            hsum_in  = hsum_ff + HSUM_W'(hr_ff);
         end
      end
      if (cmd.pop) begin
         head_in  = ptr_next(head_ff);
         count_in = count_ff - 1'b1;
         psum_in  = psum_ff - PSUM_W'(rd_ff.power);
         hsum_in  = hsum_ff - HSUM_W'(rd_ff.hr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         psum_ff  <= '0;
         hsum_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         psum_ff  <= psum_in;
         hsum_ff  <= hsum_in;
         ovf_ff   <= ovf_in;
      end
   end

   // sample memory, registered read of the head entry
   assign wr_entry = '{time_ms: time_ff, power: pwr_ff, hr: hr_ff};

   always_ff @(posedge clock) begin
      if (cmd.push && !full) begin
         fifo_mem[tail_ff] <= wr_entry;
      end
      rd_ff <= fifo_mem[head_ff];
   end

   // eviction limit in ms
   always_ff @(posedge clock) begin
      if (cmd.load_limit) begin
         limit_ff <= LIMIT_W'(sec_diff) * LIMIT_W'(MS_PER_SEC);
      end
   end

   // restoring dividers, quotient bits enter at the bottom of q
   assign hsum_x = PSUM_W'(hsum_ff);
   assign rp2    = {rem_p_ff, qp_ff[QUO_W-1]};
   assign rh2    = {rem_h_ff, qh_ff[QUO_W-1]};
   assign rp_sub = rp2 - {1'b0, res_cnt_ff};
   assign rh_sub = rh2 - {1'b0, res_cnt_ff};
   assign gep    = (rp2 >= {1'b0, res_cnt_ff});
   assign geh    = (rh2 >= {1'b0, res_cnt_ff});

   always_comb begin
      rem_p_in   = rem_p_ff;
      rem_h_in   = rem_h_ff;
      qp_in      = qp_ff;
      qh_in      = qh_ff;
      res_cnt_in = res_cnt_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.capture) begin
         qp_in      = '0;
         qh_in      = '0;
         res_cnt_in = '0;
      end else if (cmd.div_start) begin
         // quotient fits QUO_W bits, so the top part is already below the count
         rem_p_in   = psum_ff[PSUM_W-1:PWR_W];
         rem_h_in   = hsum_x[PSUM_W-1:PWR_W];
         qp_in      = {psum_ff[PWR_W-1:0], FRAC_W'(0)};
         qh_in      = {hsum_x[PWR_W-1:0], FRAC_W'(0)};
         res_cnt_in = count_ff;
         div_cnt_in = '0;
      end else if (cmd.div_step) begin
         rem_p_in   = gep ? rp_sub[CNT_W-1:0] : rp2[CNT_W-1:0];
         rem_h_in   = geh ? rh_sub[CNT_W-1:0] : rh2[CNT_W-1:0];
         qp_in      = {qp_ff[QUO_W-2:0], gep};
         qh_in      = {qh_ff[QUO_W-2:0], geh};
         div_cnt_in = div_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_p_ff   <= rem_p_in;
      rem_h_ff   <= rem_h_in;
      qp_ff      <= qp_in;
      qh_ff      <= qh_in;
      res_cnt_ff <= res_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else begin
         div_cnt_ff <= div_cnt_in;
      end
   end

   // output register
   assign cnt_wide = (CNT_W + CNT_OUT_W)'(res_cnt_ff);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_sec_ff  <= sec_ff;
         out_pavg_ff <= qp_ff;
         out_havg_ff <= qh_ff[HR_AVG_W-1:0];
         out_cnt_ff  <= cnt_wide[CNT_OUT_W-1:0];
         out_ovf_ff  <= ovf_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_second   = out_sec_ff;
   assign rsp_power_avg    = out_pavg_ff;
   assign rsp_hr_avg       = out_havg_ff;
   assign rsp_window_count = out_cnt_ff;
   assign rsp_overflow     = out_ovf_ff;

endmodule

`default_nettype wire

>>> rtl/time_window_moving_average.sv
// top level of the time window moving average block: window register and port
// depends on twma_pkg, twma_ctrl and twma_datapath
//
// two-channel (power, heart rate) moving average over a sliding time window
// req channel: one transfer per item, req_func 0 is a sample, 1 a one-second tick
//   a sample is clamped at zero power, stored in the sample fifo and summed,
//   or sets the overflow flag when the fifo is full; it gives no result
// rsp channel: one transfer per tick at or below MAX_SECONDS, carrying the
//   averages in 1/256 units, the window count and the sticky overflow flag
// a tick that is neither warm-up nor late first drops fifo entries older than
//   (second - window) * 1000 ms, one memory read turnaround per dropped head
// the averages come from the 23-step restoring dividers
//   (power and heart rate run side by side)
// warm-up tick (second below window): zeros; store empty after eviction: zeros;
//   a late tick is dropped with no result and frees the block
// one item at a time: req_stall is high while an item is being worked on; the
//   output register holds a result while rsp_stall is high, the next item is still
//   accepted and worked on, a new tick result waits for the register
// window_seconds sits at byte address 0 of the csr port, write only when idle
// reset empties the fifo, clears sums, flag and output valid, sets the window to 30 s
`default_nettype none

module time_window_moving_average
   import twma_pkg::*;
#(
   parameter int FIFO_DEPTH  = 1024,
   parameter int MAX_SECONDS = 604800
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // item input
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic                  req_func,
   input  wire logic [TIME_W-1:0]     req_sample_time_ms,
   input  wire logic [PWR_IN_W-1:0]   req_power_watts,
   input  wire logic [HR_W-1:0]       req_heart_rate,
   input  wire logic [SEC_W-1:0]      req_tick_second,
   // result output
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic [SEC_W-1:0]      rsp_out_second,
   output      logic [QUO_W-1:0]      rsp_power_avg,
   output      logic [HR_AVG_W-1:0]   rsp_hr_avg,
   output      logic [CNT_OUT_W-1:0]  rsp_window_count,
   output      logic                  rsp_overflow,
   // csr port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output      logic [CSR_DATA_W-1:0] prdata,
   output      logic                  pready
);

   twma_cmd_type     cmd;
   twma_stat_type    stat;

   logic [WIN_W-1:0] window_ff, window_in;
   logic             csr_wr;

   // csr: single register, pready is tied high
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      window_in = window_ff;
      if (csr_wr && (paddr[2] == CSR_IDX_WINDOW)) begin
         window_in = pwdata[WIN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else begin
         window_ff <= window_in;
      end
   end

   // addresses with paddr[2] set read as zero
   assign prdata = (paddr[2] == CSR_IDX_WINDOW) ? CSR_DATA_W'(window_ff) : '0;

   twma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   twma_datapath #(
      .FIFO_DEPTH  (FIFO_DEPTH),
      .MAX_SECONDS (MAX_SECONDS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .window_seconds     (window_ff),
      .req_func           (req_func),
      .req_sample_time_ms (req_sample_time_ms),
      .req_power_watts    (req_power_watts),
      .req_heart_rate     (req_heart_rate),
      .req_tick_second    (req_tick_second),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_second     (rsp_out_second),
      .rsp_power_avg      (rsp_power_avg),
      .rsp_hr_avg         (rsp_hr_avg),
      .rsp_window_count   (rsp_window_count),
      .rsp_overflow       (rsp_overflow)
   );

endmodule

`default_nettype wire

>>> rtl/twma_checker.sv
// port-level checks for the time window moving average block, bound to the top level
// depends on twma_pkg and time_window_moving_average_defines.svh
`default_nettype none
`include "time_window_moving_average_defines.svh"

module twma_checker
   import twma_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic                  req_func,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [SEC_W-1:0]      rsp_out_second,
   input wire logic [QUO_W-1:0]      rsp_power_avg,
   input wire logic [HR_AVG_W-1:0]   rsp_hr_avg,
   input wire logic [CNT_OUT_W-1:0]  rsp_window_count,
   input wire logic                  rsp_overflow,
   input wire logic                  psel,
   input wire logic                  penable,
   input wire logic                  pwrite,
   input wire logic                  pready,
   input wire logic [CSR_ADDR_W-1:0] paddr,
   input wire logic [CSR_DATA_W-1:0] pwdata,
   input wire logic [CSR_DATA_W-1:0] prdata
);

   logic req_xfer;
   logic smp_xfer;
   logic win_sel;
   logic cfg_wr;
   logic rd_match;
   logic [SEC_W+QUO_W+HR_AVG_W+CNT_OUT_W:0] rsp_bits;
   logic [WIN_W-1:0] wdata_ff, wdata_in;

   assign req_xfer = req_valid && !req_stall;
   assign smp_xfer = req_xfer && !req_func;
   assign win_sel  = (paddr[2] == CSR_IDX_WINDOW);
   assign cfg_wr   = psel && penable && pwrite && pready && win_sel;
   assign rd_match = (prdata[WIN_W-1:0] == wdata_ff);
   assign rsp_bits = {rsp_out_second, rsp_power_avg, rsp_hr_avg,
                      rsp_window_count, rsp_overflow};

   // last value written to the window register
   always_comb begin
      wdata_in = wdata_ff;
      if (cfg_wr) begin
         wdata_in = pwdata[WIN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wdata_ff <= WINDOW_RESET;
      end else begin
         wdata_ff <= wdata_in;
      end
   end

   `TWMA_ASSERT_NEXT(a_rsp_valid_held, rsp_valid && rsp_stall, rsp_valid, "result dropped")
   `TWMA_ASSERT_NEXT(a_rsp_data_held, rsp_valid && rsp_stall, $stable(rsp_bits), "result changed")
   `TWMA_ASSERT_NEXT(a_busy_after_item, req_xfer, req_stall, "item accepted without going busy")
   `TWMA_ASSERT_NEXT(a_sample_no_result, smp_xfer, !$rose(rsp_valid), "sample produced a result")
   `TWMA_ASSERT_NEXT(a_window_readback, cfg_wr, !win_sel || rd_match, "window readback mismatch")

endmodule

bind time_window_moving_average twma_checker u_twma_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_func         (req_func),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_out_second   (rsp_out_second),
   .rsp_power_avg    (rsp_power_avg),
   .rsp_hr_avg       (rsp_hr_avg),
   .rsp_window_count (rsp_window_count),
   .rsp_overflow     (rsp_overflow),
   .psel             (psel),
   .penable          (penable),
   .pwrite           (pwrite),
   .pready           (pready),
   .paddr            (paddr),
   .pwdata           (pwdata),
   .prdata           (prdata)
);

`default_nettype wire
